// ===== src/assert_macros.svh =====
// Assertion helpers shared by the tokenizer modules.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

// ===== src/stt_pkg.sv =====
`default_nettype none

package stt_pkg;

    // Most result items one text byte can cause.
    localparam int MAX_RES    = 3;
    localparam int RES_IDX_W  = $clog2(MAX_RES + 1);

    // Result queue sizing.
    localparam int Q_DEPTH    = 8;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
    localparam logic [Q_CNT_W-1:0] Q_LIMIT = Q_CNT_W'(Q_DEPTH - MAX_RES);
    localparam logic [Q_CNT_W-1:0] Q_FULL  = Q_CNT_W'(Q_DEPTH);

    // Token classes.
    localparam logic [1:0] CLS_IDEN = 2'd0;
    localparam logic [1:0] CLS_NUM  = 2'd1;
    localparam logic [1:0] CLS_STR  = 2'd2;

    // Event codes.
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_UNKNOWN  = 2'd1;
    localparam logic [1:0] EV_STR_OPEN = 2'd2;

    // Characters with a special meaning to the scanner.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SOH    = 8'h01;
    localparam logic [7:0] CH_ENQ    = 8'h05;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    // One result item.
    typedef struct packed {
        logic [1:0] token_class;
        logic [7:0] out_byte;
        logic       carries_byte;
        logic       token_first;
        logic       token_close;
        logic [1:0] event_code;
        logic       run_last;
    } result_t;

    // Results of one text byte, handed from the scanner to the queue.
    typedef struct packed {
        logic [RES_IDX_W-1:0]        cnt;
        result_t [MAX_RES-1:0]       res;
    } lex_out_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_id_start(input logic [7:0] b);
        return ((b >= CH_LO_A) && (b <= CH_LO_Z)) ||
               ((b >= CH_UP_A) && (b <= CH_UP_Z)) || (b == CH_UNDER);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_SOH) ||
               (b == CH_ENQ) || (b == CH_LF) || (b == CH_CR);
    endfunction

endpackage

`default_nettype wire

// ===== src/stt_lexer.sv =====
`default_nettype none

module stt_lexer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_fire,
    input  wire logic [7:0]       text_byte,
    input  wire logic             final_byte,
    output stt_pkg::lex_out_t     lex
);
    import stt_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IDEN  = 3'd1,
        MODE_NUM   = 3'd2,
        MODE_STR   = 3'd3,
        MODE_SLASH = 3'd4,
        MODE_LINE  = 3'd5,
        MODE_BLOCK = 3'd6
    } mode_t;

    // Outcome of a byte seen between tokens.
    typedef struct packed {
        mode_t   mode;
        logic    emits;
        logic    clr_bslash;
        logic    empty;
        result_t res;
    } idle_t;

    mode_t mode_reg, mode_next;
    logic  bslash_reg, bslash_next;
    logic  star_reg, star_next;
    logic  empty_reg, empty_next;

    function automatic result_t mk_res(input logic [1:0] cls, input logic [7:0] b,
                                       input logic carries, input logic first,
                                       input logic close, input logic [1:0] ev);
        result_t r;
        r.token_class  = cls;
        r.out_byte     = b;
        r.carries_byte = carries;
        r.token_first  = first;
        r.token_close  = close;
        r.event_code   = ev;
        r.run_last     = 1'b0;
        return r;
    endfunction

    // Classify a byte that arrives while no token is open.
    function automatic idle_t idle_step(input logic [7:0] b);
        idle_t s;
        s.mode       = MODE_IDLE;
        s.emits      = 1'b0;
        s.clr_bslash = 1'b0;
        s.empty      = 1'b1;
        s.res        = mk_res(CLS_IDEN, b, 1'b0, 1'b0, 1'b0, EV_UNKNOWN);
        if (b == CH_QUOTE) begin
            s.mode       = MODE_STR;
            s.clr_bslash = 1'b1;
        end else if (b == CH_SLASH) begin
            s.mode = MODE_SLASH;
        end else if (is_space(b)) begin
            s.mode = MODE_IDLE;
        end else if (is_digit(b)) begin
            s.mode  = MODE_NUM;
            s.emits = 1'b1;
            s.empty = 1'b0;
            s.res   = mk_res(CLS_NUM, b, 1'b1, 1'b1, 1'b0, EV_NONE);
        end else if (is_id_start(b)) begin
            s.mode  = MODE_IDEN;
            s.emits = 1'b1;
            s.empty = 1'b0;
            s.res   = mk_res(CLS_IDEN, b, 1'b1, 1'b1, 1'b0, EV_NONE);
        end else begin
            s.emits = 1'b1;
        end
        return s;
    endfunction

    // Next scanner state and the results of the current byte.
    always_comb
    begin
        idle_t                idl;
        logic [RES_IDX_W-1:0] n;
        result_t [MAX_RES-1:0] res;

        idl         = idle_step(text_byte);
        n           = '0;
        res         = '0;
        mode_next   = mode_reg;
        bslash_next = bslash_reg;
        star_next   = star_reg;
        empty_next  = empty_reg;

        unique case (mode_reg)
            MODE_IDEN, MODE_NUM:
            begin
                if ((mode_reg == MODE_IDEN &&
                     (is_id_start(text_byte) || is_digit(text_byte))) ||
                    (mode_reg == MODE_NUM &&
                     (is_digit(text_byte) || text_byte == CH_DOT))) begin
                    res[n] = mk_res((mode_reg == MODE_IDEN) ? CLS_IDEN : CLS_NUM,
                                    text_byte, 1'b1, empty_reg, 1'b0, EV_NONE);
                    n          = n + 1'b1;
                    empty_next = 1'b0;
                end else begin
                    res[n] = mk_res((mode_reg == MODE_IDEN) ? CLS_IDEN : CLS_NUM,
                                    CH_NUL, 1'b0, empty_reg, 1'b1, EV_NONE);
                    n = n + 1'b1;
                    if (idl.emits) begin
                        res[n] = idl.res;
                        n      = n + 1'b1;
                    end
                    mode_next  = idl.mode;
                    empty_next = idl.empty;
                    if (idl.clr_bslash) begin
                        bslash_next = 1'b0;
                    end
                end
            end
            MODE_STR:
            begin
                if (text_byte == CH_QUOTE && !bslash_reg) begin
                    res[n]     = mk_res(CLS_STR, CH_NUL, 1'b0, empty_reg, 1'b1, EV_NONE);
                    n          = n + 1'b1;
                    empty_next = 1'b1;
                    mode_next  = MODE_IDLE;
                end else if (text_byte == CH_NUL) begin
                    res[n]     = mk_res(CLS_STR, CH_NUL, 1'b0, empty_reg, 1'b1,
                                        EV_STR_OPEN);
                    n          = n + 1'b1;
                    empty_next = 1'b1;
                    mode_next  = MODE_IDLE;
                end else begin
                    res[n]      = mk_res(CLS_STR, text_byte, 1'b1, empty_reg, 1'b0, EV_NONE);
                    n           = n + 1'b1;
                    empty_next  = 1'b0;
                    bslash_next = (text_byte == CH_BSLASH);
                end
            end
            MODE_SLASH:
            begin
                if (text_byte == CH_SLASH) begin
                    mode_next = MODE_LINE;
                end else if (text_byte == CH_STAR) begin
                    mode_next = MODE_BLOCK;
                    star_next = 1'b0;
                end else begin
                    // The held slash had no comment after it.
                    res[n] = mk_res(CLS_IDEN, CH_SLASH, 1'b0, 1'b0, 1'b0, EV_UNKNOWN);
                    n      = n + 1'b1;
                    if (idl.emits) begin
                        res[n] = idl.res;
                        n      = n + 1'b1;
                    end
                    mode_next  = idl.mode;
                    empty_next = idl.empty;
                    if (idl.clr_bslash) begin
                        bslash_next = 1'b0;
                    end
                end
            end
            MODE_LINE:
            begin
                if (text_byte == CH_LF || text_byte == CH_CR) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_BLOCK:
            begin
                if (star_reg && text_byte == CH_SLASH) begin
                    mode_next = MODE_IDLE;
                end else begin
                    star_next = (text_byte == CH_STAR);
                end
            end
            default:
            begin
                if (idl.emits) begin
                    res[n] = idl.res;
                    n      = n + 1'b1;
                end
                mode_next  = idl.mode;
                empty_next = idl.empty;
                if (idl.clr_bslash) begin
                    bslash_next = 1'b0;
                end
            end
        endcase

        // End of text closes whatever is still open.
        if (final_byte) begin
            priority if (mode_next == MODE_IDEN) begin
                res[n] = mk_res(CLS_IDEN, CH_NUL, 1'b0, empty_next, 1'b1, EV_NONE);
                n      = n + 1'b1;
            end else if (mode_next == MODE_NUM) begin
                res[n] = mk_res(CLS_NUM, CH_NUL, 1'b0, empty_next, 1'b1, EV_NONE);
                n      = n + 1'b1;
            end else if (mode_next == MODE_STR) begin
                res[n] = mk_res(CLS_STR, CH_NUL, 1'b0, empty_next, 1'b1, EV_STR_OPEN);
                n      = n + 1'b1;
            end else if (mode_next == MODE_SLASH) begin
                res[n] = mk_res(CLS_IDEN, CH_SLASH, 1'b0, 1'b0, 1'b0, EV_UNKNOWN);
                n      = n + 1'b1;
            end else begin
                n = n;
            end
            mode_next   = MODE_IDLE;
            bslash_next = 1'b0;
            star_next   = 1'b0;
            empty_next  = 1'b1;
        end

        // Mark the last result of this byte.
        if (n != '0) begin
            res[n - 1'b1].run_last = 1'b1;
        end

        lex.cnt = n;
        lex.res = res;
    end

    // Scanner state advances once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= MODE_IDLE;
            bslash_reg <= 1'b0;
            star_reg   <= 1'b0;
            empty_reg  <= 1'b1;
        end else if (in_fire) begin
            mode_reg   <= mode_next;
            bslash_reg <= bslash_next;
            star_reg   <= star_next;
            empty_reg  <= empty_next;
        end
    end

    `ASSERT_NEXT(a_final_returns_idle, in_fire && final_byte,
                 mode_reg == MODE_IDLE && empty_reg && !star_reg)
    `ASSERT_NOW(a_open_token_has_bytes, mode_reg == MODE_IDEN || mode_reg == MODE_NUM,
                !empty_reg)

endmodule

`default_nettype wire

// ===== src/stt_out_queue.sv =====
`default_nettype none

module stt_out_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [stt_pkg::RES_IDX_W-1:0] push_cnt,
    input  stt_pkg::result_t [stt_pkg::MAX_RES-1:0] push_res,
    output logic                    has_room,
    output logic                    head_valid,
    input  wire logic               head_pop,
    output stt_pkg::result_t        head_res
);
    import stt_pkg::*;

    `include "assert_macros.svh"

    result_t              mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   head_reg, head_next;
    logic [Q_PTR_W-1:0]   tail_reg, tail_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 pop;

    // Room for the largest burst one item can cause.
    assign has_room   = (count_reg <= Q_LIMIT);
    assign head_valid = (count_reg != '0);
    assign head_res   = mem[head_reg];
    assign pop        = head_valid && head_pop;

    assign tail_next  = tail_reg + Q_PTR_W'(push_cnt);
    assign head_next  = head_reg + Q_PTR_W'(pop);
    assign count_next = count_reg + Q_CNT_W'(push_cnt) - Q_CNT_W'(pop);

    // Result storage: up to MAX_RES entries written per cycle.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (RES_IDX_W'(i) < push_cnt) begin
                mem[tail_reg + Q_PTR_W'(i)] <= push_res[i];
            end
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    `ASSERT_NOW(a_count_bound, 1'b1, count_reg <= Q_FULL)
    `ASSERT_NEXT(a_push_not_empty, push_cnt != '0, count_reg != '0)

endmodule

`default_nettype wire

// ===== src/source_text_tokenizer_core.sv =====
`default_nettype none

// Byte-stream tokenizer. Accepts one text byte per cycle while the queue has
// room and emits the identifier, number and string-content bytes it finds,
// with separate close items, plus events for unknown bytes and unterminated
// strings; whitespace and comments produce nothing. Each accepted item is
// classified in the same cycle and its zero to three result items land in
// an eight-entry result queue, so with an empty queue the first result is
// offered the cycle after acceptance. The queue drains one result per cycle
// while out_ready is high: input runs at one item per cycle while items
// average at most one result, and otherwise the output side sets the
// sustained rate. An item is taken only when the queue has three free entries.
module source_text_tokenizer_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] text_byte,
    input  wire logic       final_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      token_class,
    output logic [7:0]      out_byte,
    output logic            carries_byte,
    output logic            token_first,
    output logic            token_close,
    output logic [1:0]      event_code,
    output logic            run_last
);
    import stt_pkg::*;

    logic                  in_fire;
    logic                  has_room;
    lex_out_t              lex;
    logic [RES_IDX_W-1:0]  push_cnt;
    result_t               head_res;

    assign in_ready = has_room;
    assign in_fire  = in_valid && has_room;
    assign push_cnt = in_fire ? lex.cnt : '0;

    // Character classification and scanner state.
    stt_lexer u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .text_byte  (text_byte),
        .final_byte (final_byte),
        .lex        (lex)
    );

    // Result queue between the scanner and the output port.
    stt_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push_res   (lex.res),
        .has_room   (has_room),
        .head_valid (out_valid),
        .head_pop   (out_ready),
        .head_res   (head_res)
    );

    assign token_class  = head_res.token_class;
    assign out_byte     = head_res.out_byte;
    assign carries_byte = head_res.carries_byte;
    assign token_first  = head_res.token_first;
    assign token_close  = head_res.token_close;
    assign event_code   = head_res.event_code;
    assign run_last     = head_res.run_last;

endmodule

`default_nettype wire
